[sv/jacobian_2x2_stability_check_defines.svh]
// Shared assertion macros for the Jacobian stability check.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef JACOBIAN_2X2_STABILITY_CHECK_DEFINES_SVH
`define JACOBIAN_2X2_STABILITY_CHECK_DEFINES_SVH

// Same-cycle implication.
`define JAC_CHK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define JAC_CHK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/jac_pkg.sv]
`timescale 1ns / 1ps

package jac_pkg;

    localparam int IN_W       = 24;
    localparam int HALF_W     = 12 * 2;
    localparam int TEMP_W     = 16;
    localparam int REG_W      = 16;
    localparam int OUT_W      = 49;
    localparam int DET_W      = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int FIFO_DEPTH = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_COLD_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_TOL  = 1'b1;

    localparam logic [REG_W-1:0] COLD_LIMIT_RST = 16'd1280;
    localparam logic [REG_W-1:0] BOUND_TOL_RST  = 16'd0;

    // Stability status codes.
    localparam logic [1:0] ST_CONTRACT = 2'd0;
    localparam logic [1:0] ST_BOUNDARY = 2'd1;
    localparam logic [1:0] ST_LOST     = 2'd2;

    // Scores in Q0.16.
    localparam logic [15:0] ECO_CONTRACT_COLD = 16'd21627;
    localparam logic [15:0] ECO_CONTRACT_WARM = 16'd27525;
    localparam logic [15:0] ECO_LOST_COLD     = 16'd5407;
    localparam logic [15:0] ECO_LOST_WARM     = 16'd6881;
    localparam logic [15:0] HARM_LOW          = 16'd16384;
    localparam logic [15:0] HARM_HIGH         = 16'd52429;

    localparam logic [DET_W-1:0] DET_MAX = '1;

    typedef struct packed {
        logic is_real;
        logic kf_cold;
    } t_cls;

endpackage

[sv/jac_front.sv]
`timescale 1ns / 1ps

module jac_front import jac_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic [IN_W-1:0]                   i_conc,
    input  logic [IN_W-1:0]                   i_sed,
    input  logic [IN_W-1:0]                   i_rem,
    input  logic [IN_W-1:0]                   i_part,
    input  logic [IN_W-1:0]                   i_rel,
    input  logic [IN_W-1:0]                   i_sett,
    input  logic [TEMP_W-1:0]                 i_temp,
    input  logic [REG_W-1:0]                  i_cold_limit,
    output logic                              o_vld,
    output logic [2*IN_W-FRAC_BITS:0]         o_amag,
    output logic [2*IN_W-FRAC_BITS-1:0]       o_pmag,
    output logic [2*IN_W-FRAC_BITS+1:0]       o_tsum,
    output logic [DET_W-1:0]                  o_det,
    output logic [2*(2*IN_W+1-FRAC_BITS)-1:0] o_disc,
    output t_cls                              o_cls
);

    localparam int AM_W   = 2 * IN_W + 1 - FRAC_BITS;
    localparam int PM_W   = 2 * IN_W - FRAC_BITS;
    localparam int TS_W   = AM_W + 1;
    localparam int AS_W   = AM_W + IN_W;
    localparam int PR_W   = PM_W + IN_W;
    localparam int SUM_W  = AS_W + 1;
    localparam int DISC_W = 2 * AM_W;
    localparam int CMP_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;
    localparam int PP_W   = 2 * HALF_W;
    localparam int ASF_W  = 3 * HALF_W;
    localparam int SQF_W  = 4 * HALF_W;

    // Stage A: input capture.
    logic              r_a_vld;
    logic [IN_W-1:0]   r_a_conc, r_a_sed, r_a_rem, r_a_part, r_a_rel, r_a_sett;
    logic [TEMP_W-1:0] r_a_temp;
    // Stage B: first products.
    logic              r_b_vld;
    logic [PP_W-1:0]   r_b_ps, r_b_pc;
    logic [IN_W-1:0]   r_b_rem, r_b_rel, r_b_sett;
    logic              r_b_cold;
    // Stage C: Jacobian magnitudes.
    logic              r_c_vld;
    logic [AM_W-1:0]   r_c_amag;
    logic [PM_W-1:0]   r_c_pmag;
    logic [IN_W-1:0]   r_c_rel, r_c_sett;
    logic              r_c_cold;
    // Stage D: split products and the diagonal difference.
    logic              r_d_vld;
    logic [PP_W-1:0]   r_d_al, r_d_ah, r_d_pl, r_d_ph;
    logic [AM_W-1:0]   r_d_diff, r_d_amag;
    logic [PM_W-1:0]   r_d_pmag;
    logic [TS_W-1:0]   r_d_tsum;
    logic              r_d_cold;
    // Stage E: joined products and square pieces.
    logic              r_e_vld;
    logic [AS_W-1:0]   r_e_as;
    logic [PR_W-1:0]   r_e_pr;
    logic [PP_W-1:0]   r_e_sll, r_e_slh, r_e_shh;
    logic [AM_W-1:0]   r_e_amag;
    logic [PM_W-1:0]   r_e_pmag;
    logic [TS_W-1:0]   r_e_tsum;
    logic              r_e_cold;
    // Stage F: determinant sum, four times the off-diagonal product, square.
    logic              r_f_vld;
    logic [SUM_W-1:0]  r_f_sum;
    logic [DISC_W-1:0] r_f_four, r_f_sq;
    logic [AM_W-1:0]   r_f_amag;
    logic [PM_W-1:0]   r_f_pmag;
    logic [TS_W-1:0]   r_f_tsum;
    logic              r_f_cold;
    // Stage G: classification.
    logic              r_g_vld;
    logic [DET_W-1:0]  r_g_det;
    logic [DISC_W-1:0] r_g_disc;
    logic [AM_W-1:0]   r_g_amag;
    logic [PM_W-1:0]   r_g_pmag;
    logic [TS_W-1:0]   r_g_tsum;
    t_cls              r_g_cls;

    logic [PP_W-1:0]   w_amag_p, w_pmag_p, w_diff_p;
    logic [SUM_W-1:0]  w_det_sh;
    logic              w_det_sat, w_real;

    assign w_amag_p  = PP_W'(r_c_amag);
    assign w_pmag_p  = PP_W'(r_c_pmag);
    assign w_diff_p  = PP_W'(r_d_diff);
    assign w_det_sh  = r_f_sum >> FRAC_BITS;
    assign w_det_sat = CMP_W'(w_det_sh) > CMP_W'(DET_MAX);
    assign w_real    = r_f_four <= r_f_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_conc <= i_conc;
        r_a_sed  <= i_sed;
        r_a_rem  <= i_rem;
        r_a_part <= i_part;
        r_a_rel  <= i_rel;
        r_a_sett <= i_sett;
        r_a_temp <= i_temp;

        r_b_ps   <= r_a_part * r_a_sed;
        r_b_pc   <= r_a_part * r_a_conc;
        r_b_rem  <= r_a_rem;
        r_b_rel  <= r_a_rel;
        r_b_sett <= r_a_sett;
        r_b_cold <= r_a_temp <= i_cold_limit;

        r_c_amag <= AM_W'(r_b_rem) + AM_W'(r_b_ps >> FRAC_BITS);
        r_c_pmag <= PM_W'(r_b_pc >> FRAC_BITS);
        r_c_rel  <= r_b_rel;
        r_c_sett <= r_b_sett;
        r_c_cold <= r_b_cold;

        r_d_al   <= w_amag_p[HALF_W-1:0] * r_c_sett;
        r_d_ah   <= w_amag_p[PP_W-1:HALF_W] * r_c_sett;
        r_d_pl   <= w_pmag_p[HALF_W-1:0] * r_c_rel;
        r_d_ph   <= w_pmag_p[PP_W-1:HALF_W] * r_c_rel;
        r_d_diff <= (r_c_amag >= AM_W'(r_c_sett)) ? r_c_amag - AM_W'(r_c_sett)
                                                 : AM_W'(r_c_sett) - r_c_amag;
        r_d_tsum <= TS_W'(r_c_amag) + TS_W'(r_c_sett);
        r_d_amag <= r_c_amag;
        r_d_pmag <= r_c_pmag;
        r_d_cold <= r_c_cold;

        r_e_as   <= AS_W'(ASF_W'(r_d_al) + (ASF_W'(r_d_ah) << HALF_W));
        r_e_pr   <= PR_W'(ASF_W'(r_d_pl) + (ASF_W'(r_d_ph) << HALF_W));
        r_e_sll  <= w_diff_p[HALF_W-1:0] * w_diff_p[HALF_W-1:0];
        r_e_slh  <= w_diff_p[HALF_W-1:0] * w_diff_p[PP_W-1:HALF_W];
        r_e_shh  <= w_diff_p[PP_W-1:HALF_W] * w_diff_p[PP_W-1:HALF_W];
        r_e_amag <= r_d_amag;
        r_e_pmag <= r_d_pmag;
        r_e_tsum <= r_d_tsum;
        r_e_cold <= r_d_cold;

        // The cross term appears twice in the square, hence the extra bit of shift.
        r_f_sum  <= SUM_W'(r_e_as) + SUM_W'(r_e_pr);
        r_f_four <= DISC_W'({r_e_pr, 2'b00});
        r_f_sq   <= DISC_W'(SQF_W'(r_e_sll) + (SQF_W'(r_e_slh) << (HALF_W + 1))
                            + (SQF_W'(r_e_shh) << PP_W));
        r_f_amag <= r_e_amag;
        r_f_pmag <= r_e_pmag;
        r_f_tsum <= r_e_tsum;
        r_f_cold <= r_e_cold;

        r_g_det          <= w_det_sat ? DET_MAX : DET_W'(w_det_sh);
        r_g_disc         <= w_real ? r_f_sq - r_f_four : r_f_four - r_f_sq;
        r_g_cls.is_real  <= w_real;
        r_g_cls.kf_cold  <= r_f_cold;
        r_g_amag         <= r_f_amag;
        r_g_pmag         <= r_f_pmag;
        r_g_tsum         <= r_f_tsum;
    end

    assign o_vld  = r_g_vld;
    assign o_amag = r_g_amag;
    assign o_pmag = r_g_pmag;
    assign o_tsum = r_g_tsum;
    assign o_det  = r_g_det;
    assign o_disc = r_g_disc;
    assign o_cls  = r_g_cls;

endmodule

[sv/jac_fifo.sv]
`timescale 1ns / 1ps
`include "jacobian_2x2_stability_check_defines.svh"

module jac_fifo import jac_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_vld,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_full, w_empty, w_pop;

    assign w_full  = r_cnt == CNT_W'(DEPTH);
    assign w_empty = r_cnt == '0;
    // The back end never stalls, so a waiting word always leaves.
    assign w_pop   = !w_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_vld  = !w_empty;
    assign o_data = r_mem[r_rp];
    assign o_full = w_full;

    `JAC_CHK_IMP(a_fifo_no_overrun, i_push, !w_full, "queue written while full")
    `JAC_CHK_NXT(a_fifo_keeps_word, i_push && w_empty, !w_empty, "queue lost a word")

endmodule

[sv/jac_sqrt.sv]
`timescale 1ns / 1ps

module jac_sqrt #(
    parameter int RW = 33,
    parameter int SW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    // One root bit per stage, restoring digit recurrence.
    logic            w_vld  [0:RW];
    logic [RW:0]     w_rem  [0:RW];
    logic [RW-1:0]   w_root [0:RW];
    logic [2*RW-1:0] w_rad  [0:RW];
    logic [SW-1:0]   w_side [0:RW];

    assign w_vld[0]  = i_vld;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_rad[0]  = i_rad;
    assign w_side[0] = i_side;

    for (genvar i = 1; i <= RW; i++) begin : g_stage
        logic            r_vld;
        logic [RW:0]     r_rem;
        logic [RW-1:0]   r_root;
        logic [2*RW-1:0] r_rad;
        logic [SW-1:0]   r_side;
        logic [RW+2:0]   n_shift, n_trial;
        logic            n_ge;

        assign n_shift = {w_rem[i-1], w_rad[i-1][2*RW-1:2*RW-2]};
        assign n_trial = (RW + 3)'({w_root[i-1], 2'b01});
        assign n_ge    = n_shift >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem  <= (RW + 1)'(n_ge ? n_shift - n_trial : n_shift);
            r_root <= {w_root[i-1][RW-2:0], n_ge};
            r_rad  <= {w_rad[i-1][2*RW-3:0], 2'b00};
            r_side <= w_side[i-1];
        end

        assign w_vld[i]  = r_vld;
        assign w_rem[i]  = r_rem;
        assign w_root[i] = r_root;
        assign w_rad[i]  = r_rad;
        assign w_side[i] = r_side;
    end

    assign o_vld  = w_vld[RW];
    assign o_root = w_root[RW];
    assign o_side = w_side[RW];

endmodule

[sv/jac_back.sv]
`timescale 1ns / 1ps

module jac_back import jac_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic [2*IN_W-FRAC_BITS:0]         i_amag,
    input  logic [2*IN_W-FRAC_BITS-1:0]       i_pmag,
    input  logic [2*IN_W-FRAC_BITS+1:0]       i_tsum,
    input  logic [DET_W-1:0]                  i_det,
    input  logic [2*(2*IN_W+1-FRAC_BITS)-1:0] i_disc,
    input  t_cls                              i_cls,
    input  logic [REG_W-1:0]                  i_tol,
    output logic                              o_vld,
    output logic [OUT_W-1:0]                  o_j11,
    output logic [OUT_W-1:0]                  o_j12,
    output logic [OUT_W-1:0]                  o_trace,
    output logic [OUT_W-1:0]                  o_det,
    output logic [OUT_W-1:0]                  o_r1,
    output logic [OUT_W-1:0]                  o_i1,
    output logic [OUT_W-1:0]                  o_r2,
    output logic [OUT_W-1:0]                  o_i2,
    output logic [OUT_W-1:0]                  o_mx,
    output logic [1:0]                        o_status,
    output logic [15:0]                       o_eco,
    output logic [15:0]                       o_harm
);

    localparam int AM_W = 2 * IN_W + 1 - FRAC_BITS;
    localparam int PM_W = 2 * IN_W - FRAC_BITS;
    localparam int TS_W = AM_W + 1;
    localparam int SW   = AM_W + PM_W + TS_W + DET_W + $bits(t_cls);
    localparam int XW   = OUT_W + 1;
    localparam int SHL  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SHR  = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

    logic              s_vld;
    logic [AM_W-1:0]   s_root, s_amag;
    logic [PM_W-1:0]   s_pmag;
    logic [TS_W-1:0]   s_tsum;
    logic [DET_W-1:0]  s_det;
    t_cls              s_cls;
    logic [SW-1:0]     s_side;

    jac_sqrt #(
        .RW (AM_W),
        .SW (SW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_vld),
        .i_rad   (i_disc),
        .i_side  ({i_amag, i_pmag, i_tsum, i_det, i_cls}),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    assign {s_amag, s_pmag, s_tsum, s_det, s_cls} = s_side;

    logic signed [XW-1:0] w_tr, w_rt, w_sp, w_sm;
    logic [OUT_W-1:0]     w_ihalf, w_tol;
    logic [OUT_W-1:0]     n_r1, n_r2, n_i1, n_i2;
    logic [1:0]           n_status;
    logic                 w_contract;

    assign w_tr    = -$signed(XW'(s_tsum));
    assign w_rt    = $signed(XW'(s_root));
    assign w_sp    = w_tr + w_rt;
    assign w_sm    = w_tr - w_rt;
    assign w_ihalf = OUT_W'(s_root >> 1);
    assign w_tol   = (OUT_W'(i_tol) << SHL) >> SHR;

    always_comb begin
        if (s_cls.is_real) begin
            n_r1 = OUT_W'(w_sp >>> 1);
            n_r2 = OUT_W'(w_sm >>> 1);
            n_i1 = '0;
            n_i2 = '0;
        end else begin
            n_r1 = OUT_W'(w_tr >>> 1);
            n_r2 = OUT_W'(w_tr >>> 1);
            n_i1 = w_ihalf;
            n_i2 = -w_ihalf;
        end
    end

    // The first real part is always the larger one.
    assign w_contract = n_r1[OUT_W-1];
    always_comb begin
        if (w_contract) begin
            n_status = ST_CONTRACT;
        end else if (n_r1 <= w_tol) begin
            n_status = ST_BOUNDARY;
        end else begin
            n_status = ST_LOST;
        end
    end

    logic r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_j11    <= -OUT_W'(s_amag);
        o_j12    <= -OUT_W'(s_pmag);
        o_trace  <= OUT_W'(w_tr);
        o_det    <= OUT_W'(s_det);
        o_r1     <= n_r1;
        o_r2     <= n_r2;
        o_i1     <= n_i1;
        o_i2     <= n_i2;
        o_mx     <= n_r1;
        o_status <= n_status;
        if (w_contract) begin
            o_eco  <= s_cls.kf_cold ? ECO_CONTRACT_COLD : ECO_CONTRACT_WARM;
            o_harm <= HARM_LOW;
        end else begin
            o_eco  <= s_cls.kf_cold ? ECO_LOST_COLD : ECO_LOST_WARM;
            o_harm <= HARM_HIGH;
        end
    end

    assign o_vld = r_vld;

endmodule

[sv/jacobian_2x2_stability_check.sv]
`timescale 1ns / 1ps
// Channel   | Ports                                           | Handshake
// ----------+-------------------------------------------------+-------------------------------
// input     | i_concentration .. i_settling_rate, i_temperature | start high, busy low
// result    | o_jac_top_left .. o_harm_score                  | o_valid strobe, one cycle
// config    | i_cfg_we, i_cfg_idx, i_cfg_data                 | i_cfg_we high, no wait
//
// One word may enter on every clock edge; busy stays low in normal operation.
// A word passes 58 - FRAC_BITS registers: seven front stages (the first loads
// at the accepting edge), one queue entry, one square-root stage per root bit
// (49 - FRAC_BITS), and one output register, which strobes its result. The
// square-root pipeline holds most of these registers.
// Reset (synchronous, active low) empties every stage and the queue and loads
// the register reset values. The receiver cannot stall, so results never wait.
`include "jacobian_2x2_stability_check_defines.svh"

module jacobian_2x2_stability_check import jac_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [IN_W-1:0]            i_concentration,
    input  logic [IN_W-1:0]            i_sediment_level,
    input  logic [IN_W-1:0]            i_removal_rate,
    input  logic [IN_W-1:0]            i_partition_rate,
    input  logic [IN_W-1:0]            i_release_rate,
    input  logic [IN_W-1:0]            i_settling_rate,
    input  logic [TEMP_W-1:0]          i_temperature,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [REG_W-1:0]           i_cfg_data,
    output logic                       o_valid,
    output logic signed [OUT_W-1:0]    o_jac_top_left,
    output logic signed [OUT_W-1:0]    o_jac_top_right,
    output logic signed [OUT_W-1:0]    o_trace_value,
    output logic signed [OUT_W-1:0]    o_determinant_value,
    output logic signed [OUT_W-1:0]    o_first_real,
    output logic signed [OUT_W-1:0]    o_first_imag,
    output logic signed [OUT_W-1:0]    o_second_real,
    output logic signed [OUT_W-1:0]    o_second_imag,
    output logic signed [OUT_W-1:0]    o_max_real_part,
    output logic [1:0]                 o_stability_status,
    output logic [15:0]                o_eco_impact,
    output logic [15:0]                o_harm_score
);

    localparam int AM_W   = 2 * IN_W + 1 - FRAC_BITS;
    localparam int PM_W   = 2 * IN_W - FRAC_BITS;
    localparam int TS_W   = AM_W + 1;
    localparam int DISC_W = 2 * AM_W;
    localparam int QW     = AM_W + PM_W + TS_W + DET_W + DISC_W + $bits(t_cls);

    // Configuration registers. The user writes only while idle; the block does not check.
    logic [REG_W-1:0] r_cold_limit, r_bound_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cold_limit <= COLD_LIMIT_RST;
            r_bound_tol  <= BOUND_TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLD_LIMIT: r_cold_limit <= i_cfg_data;
                CFG_BOUND_TOL:  r_bound_tol  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: Jacobian, determinant and discriminant, real or complex pair.
    logic              f_vld;
    logic [AM_W-1:0]   f_amag;
    logic [PM_W-1:0]   f_pmag;
    logic [TS_W-1:0]   f_tsum;
    logic [DET_W-1:0]  f_det;
    logic [DISC_W-1:0] f_disc;
    t_cls              f_cls;
    logic              w_accept, q_full;

    assign w_accept = start && !busy;
    assign busy     = q_full;

    jac_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (w_accept),
        .i_conc       (i_concentration),
        .i_sed        (i_sediment_level),
        .i_rem        (i_removal_rate),
        .i_part       (i_partition_rate),
        .i_rel        (i_release_rate),
        .i_sett       (i_settling_rate),
        .i_temp       (i_temperature),
        .i_cold_limit (r_cold_limit),
        .o_vld        (f_vld),
        .o_amag       (f_amag),
        .o_pmag       (f_pmag),
        .o_tsum       (f_tsum),
        .o_det        (f_det),
        .o_disc       (f_disc),
        .o_cls        (f_cls)
    );

    // Short queue between the classifying front end and the root pipeline.
    logic              q_vld;
    logic [QW-1:0]     q_data;
    logic [AM_W-1:0]   q_amag;
    logic [PM_W-1:0]   q_pmag;
    logic [TS_W-1:0]   q_tsum;
    logic [DET_W-1:0]  q_det;
    logic [DISC_W-1:0] q_disc;
    t_cls              q_cls;

    jac_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .i_data  ({f_amag, f_pmag, f_tsum, f_det, f_disc, f_cls}),
        .o_vld   (q_vld),
        .o_data  (q_data),
        .o_full  (q_full)
    );

    assign {q_amag, q_pmag, q_tsum, q_det, q_disc, q_cls} = q_data;

    // Back end: square root of the discriminant, eigenvalues and status.
    jac_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (q_vld),
        .i_amag   (q_amag),
        .i_pmag   (q_pmag),
        .i_tsum   (q_tsum),
        .i_det    (q_det),
        .i_disc   (q_disc),
        .i_cls    (q_cls),
        .i_tol    (r_bound_tol),
        .o_vld    (o_valid),
        .o_j11    (o_jac_top_left),
        .o_j12    (o_jac_top_right),
        .o_trace  (o_trace_value),
        .o_det    (o_determinant_value),
        .o_r1     (o_first_real),
        .o_i1     (o_first_imag),
        .o_r2     (o_second_real),
        .o_i2     (o_second_imag),
        .o_mx     (o_max_real_part),
        .o_status (o_stability_status),
        .o_eco    (o_eco_impact),
        .o_harm   (o_harm_score)
    );

    logic w_mx_neg, w_st_contract, w_has_imag, w_conj_ok, w_harm_low;

    assign w_mx_neg      = o_max_real_part[OUT_W-1];
    assign w_st_contract = o_stability_status == ST_CONTRACT;
    assign w_has_imag    = o_first_imag != '0;
    assign w_conj_ok     = (o_first_real == o_second_real) &&
                           (o_second_imag == -o_first_imag);
    assign w_harm_low    = o_harm_score == HARM_LOW;

    // A negative largest real part, and only that, means contracting.
    `JAC_CHK_IMP(a_status_sign, o_valid, w_st_contract == w_mx_neg, "status disagrees with sign")
    // A complex pair shares one real part and has mirrored imaginary parts.
    `JAC_CHK_IMP(a_conj_pair, o_valid && w_has_imag, w_conj_ok, "complex pair not conjugate")
    // The harm score follows the status.
    `JAC_CHK_IMP(a_harm_match, o_valid, w_harm_low == w_st_contract, "harm score disagrees")

endmodule
